// ----- design/stc_pkg.sv -----
// ----------------------------------------------------------------------------
// stc_pkg: shared types and constants for the seconds-to-calendar converter
// Holds the time constants, the control word layout of the step program,
// the step addresses and the month length lookup.
// ----------------------------------------------------------------------------
package stc_pkg;

   // time constants in seconds
   localparam logic [31:0] SEC_PER_MIN  = 32'd60;
   localparam logic [31:0] SEC_PER_HOUR = 32'd3600;
   localparam logic [31:0] SEC_PER_DAY  = 32'd86400;
   localparam logic [31:0] LOCAL_OFFSET = 32'(8 * 3600);

   localparam logic [31:0] YEAR_NORM_SECS = 32'(365 * 86400);
   localparam logic [31:0] YEAR_LEAP_SECS = 32'(366 * 86400);
   localparam logic [31:0] MON28_SECS     = 32'(28 * 86400);
   localparam logic [31:0] MON29_SECS     = 32'(29 * 86400);
   localparam logic [31:0] MON30_SECS     = 32'(30 * 86400);
   localparam logic [31:0] MON31_SECS     = 32'(31 * 86400);

   // starting point of the year walk and its leap-rule residues
   localparam logic [11:0] FIRST_YEAR   = 12'd1970;
   localparam logic [1:0]  FIRST_MOD4   = 2'd2;
   localparam logic [6:0]  FIRST_MOD100 = 7'd70;
   localparam logic [8:0]  FIRST_MOD400 = 9'd370;
   localparam logic [6:0]  LAST_MOD100  = 7'd99;
   localparam logic [8:0]  LAST_MOD400  = 9'd399;

   // month index of December (months are counted from 0)
   localparam logic [3:0] LAST_MONTH = 4'd11;

   // step program layout
   localparam int          UPC_W    = 5;
   localparam logic [4:0]  UA_YEAR  = 5'd0;
   localparam logic [4:0]  UA_MONTH = 5'd1;
   localparam logic [4:0]  UA_DAY   = 5'd2;
   localparam logic [4:0]  UA_HOUR  = 5'd7;
   localparam logic [4:0]  UA_MIN   = 5'd12;
   localparam logic [4:0]  UA_DONE  = 5'd18;

   // which quantity a step subtracts from the remaining seconds
   typedef enum logic [2:0] {
      SRC_NONE,
      SRC_YEAR,
      SRC_MONTH,
      SRC_DAY,
      SRC_HOUR,
      SRC_MIN
   } src_type;

   // one control word of the step program
   typedef struct packed {
      src_type    src;     // quantity to subtract
      logic [2:0] shift;   // left shift of that quantity (quotient bit)
      logic       rep;     // stay on this step while the subtract is taken
      logic       last;    // final step: present the result
   } ucode_word_type;

   // seconds in a month, February follows the leap flag
   function automatic logic [31:0] month_seconds(input logic [3:0] mon, input logic leap);
      logic [31:0] secs;
      case (mon)
         4'd1: begin
            secs = leap ? MON29_SECS : MON28_SECS;
         end
         4'd3, 4'd5, 4'd8, 4'd10: begin
            secs = MON30_SECS;
         end
         default: begin
            secs = MON31_SECS;
         end
      endcase
      return secs;
   endfunction

endpackage

// ----- design/stc_ucode_rom.sv -----
// ----------------------------------------------------------------------------
// stc_ucode_rom: step program of the converter
// Maps the step counter to a control word: the year walk, the month walk,
// then restoring division into days, hours and minutes, then the final step.
// ----------------------------------------------------------------------------
module stc_ucode_rom
   import stc_pkg::*;
(
   input  logic [UPC_W-1:0] upc,
   output ucode_word_type   word
);

   // decode the step address into its control word
   always_comb begin
      word = '{src: SRC_NONE, shift: 3'd0, rep: 1'b0, last: 1'b1};
      if (upc == UA_YEAR) begin
         word = '{src: SRC_YEAR, shift: 3'd0, rep: 1'b1, last: 1'b0};
      end else if (upc == UA_MONTH) begin
         word = '{src: SRC_MONTH, shift: 3'd0, rep: 1'b1, last: 1'b0};
      end else if (upc < UA_HOUR) begin
         // day quotient bits 4 down to 0
         word = '{src: SRC_DAY, shift: 3'(UA_HOUR - 5'd1 - upc), rep: 1'b0, last: 1'b0};
      end else if (upc < UA_MIN) begin
         // hour quotient bits 4 down to 0
         word = '{src: SRC_HOUR, shift: 3'(UA_MIN - 5'd1 - upc), rep: 1'b0, last: 1'b0};
      end else if (upc < UA_DONE) begin
         // minute quotient bits 5 down to 0
         word = '{src: SRC_MIN, shift: 3'(UA_DONE - 5'd1 - upc), rep: 1'b0, last: 1'b0};
      end
   end

endmodule

// ----- design/stc_datapath.sv -----
// ----------------------------------------------------------------------------
// stc_datapath: conditional-subtract datapath of the converter
// One compare and subtract per cycle on the remaining seconds, steered by the
// control word; tracks year, leap residues, month and quotient fields.
// ----------------------------------------------------------------------------
module stc_datapath
   import stc_pkg::*;
(
   input  logic           clock,
   input  logic           load,
   input  logic [31:0]    load_seconds,
   input  logic           step,
   input  ucode_word_type word,
   output logic           taken,
   output logic [11:0]    year,
   output logic [3:0]     month,
   output logic [4:0]     day,
   output logic [4:0]     hour,
   output logic [5:0]     minute,
   output logic [5:0]     second
);

   logic [31:0] rest_ff,   rest_in;
   logic [11:0] year_ff,   year_in;
   logic [1:0]  mod4_ff,   mod4_in;
   logic [6:0]  mod100_ff, mod100_in;
   logic [8:0]  mod400_ff, mod400_in;
   logic [3:0]  mon_ff,    mon_in;
   logic [4:0]  day_ff,    day_in;
   logic [4:0]  hour_ff,   hour_in;
   logic [5:0]  min_ff,    min_in;

   logic        leap;
   logic [31:0] base;
   logic [31:0] operand;

   // Gregorian rule from the tracked residues
   assign leap = ((mod4_ff == 2'd0) && (mod100_ff != 7'd0)) || (mod400_ff == 9'd0);

   // select the quantity to subtract
   always_comb begin
      case (word.src)
         SRC_YEAR:  base = leap ? YEAR_LEAP_SECS : YEAR_NORM_SECS;
         SRC_MONTH: base = month_seconds(mon_ff, leap);
         SRC_DAY:   base = SEC_PER_DAY;
         SRC_HOUR:  base = SEC_PER_HOUR;
         SRC_MIN:   base = SEC_PER_MIN;
         default:   base = 32'd0;
      endcase
   end

   assign operand = base << word.shift;

   // take the subtract when it fits; the month walk stops at December
   always_comb begin
      taken = 1'b0;
      if (word.src != SRC_NONE) begin
         taken = (rest_ff >= operand);
      end
      if ((word.src == SRC_MONTH) && (mon_ff >= LAST_MONTH)) begin
         taken = 1'b0;
      end
   end

   // next values of the datapath registers
   always_comb begin
      rest_in   = rest_ff;
      year_in   = year_ff;
      mod4_in   = mod4_ff;
      mod100_in = mod100_ff;
      mod400_in = mod400_ff;
      mon_in    = mon_ff;
      day_in    = day_ff;
      hour_in   = hour_ff;
      min_in    = min_ff;
      if (load) begin
         rest_in   = load_seconds + LOCAL_OFFSET;
         year_in   = FIRST_YEAR;
         mod4_in   = FIRST_MOD4;
         mod100_in = FIRST_MOD100;
         mod400_in = FIRST_MOD400;
         mon_in    = 4'd0;
         day_in    = 5'd0;
         hour_in   = 5'd0;
         min_in    = 6'd0;
      end else if (step && taken) begin
         rest_in = rest_ff - operand;
         case (word.src)
            SRC_YEAR: begin
               year_in   = year_ff + 12'd1;
               mod4_in   = mod4_ff + 2'd1;
               mod100_in = (mod100_ff == LAST_MOD100) ? 7'd0 : mod100_ff + 7'd1;
               mod400_in = (mod400_ff == LAST_MOD400) ? 9'd0 : mod400_ff + 9'd1;
            end
            SRC_MONTH: begin
               mon_in = mon_ff + 4'd1;
            end
            SRC_DAY: begin
               day_in = day_ff | (5'd1 << word.shift);
            end
            SRC_HOUR: begin
               hour_in = hour_ff | (5'd1 << word.shift);
            end
            SRC_MIN: begin
               min_in = min_ff | (6'd1 << word.shift);
            end
            default: begin
               rest_in = rest_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      rest_ff   <= rest_in;
      year_ff   <= year_in;
      mod4_ff   <= mod4_in;
      mod100_ff <= mod100_in;
      mod400_ff <= mod400_in;
      mon_ff    <= mon_in;
      day_ff    <= day_in;
      hour_ff   <= hour_in;
      min_ff    <= min_in;
   end

   assign year   = year_ff;
   assign month  = mon_ff + 4'd1;
   assign day    = day_ff + 5'd1;
   assign hour   = hour_ff;
   assign minute = min_ff;
   assign second = rest_ff[5:0];

endmodule

// ----- design/seconds_to_calendar.sv -----
// ----------------------------------------------------------------------------
// seconds_to_calendar: Unix seconds to UTC+8 calendar date and time of day
// Microcoded converter: a step counter walks a short program that drives a
// conditional-subtract datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with req_unix_seconds; the word is taken at a clock edge
//   where start is high and busy is low. busy then stays high until the
//   conversion finishes.
//   The result appears on the rsp_ ports for exactly one cycle, marked by
//   rsp_valid, which rises at the edge where busy falls. The receiver cannot
//   hold it off; the fields are gone once the next word is loaded.
//   Steps: while busy is high the year step repeats once per whole year past
//   1970 (0..136) and then moves on, and the month step once per whole month
//   past January (0..11) and then moves on; restoring division then gives the
//   day, hour and minute, and a final step presents the result. The 32-bit
//   count ends in February 2106, so the longest conversion is December 2105.
//   One 32-bit compare and subtract does the walk, one year or month per
//   cycle. A new word may be started in the cycle rsp_valid is high.
//   Reset: synchronous, active high; clears busy and rsp_valid and drops any
//   conversion in flight.
// ----------------------------------------------------------------------------
module seconds_to_calendar
   import stc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_unix_seconds,
   output logic        rsp_valid,
   output logic [11:0] rsp_year,
   output logic [3:0]  rsp_month,
   output logic [4:0]  rsp_day,
   output logic [4:0]  rsp_hour,
   output logic [5:0]  rsp_minute,
   output logic [5:0]  rsp_second
);

   logic             busy_ff,  busy_in;
   logic             valid_ff, valid_in;
   logic [UPC_W-1:0] upc_ff,   upc_in;

   logic             load;
   logic             taken;
   ucode_word_type   word;

   assign load = start && !busy_ff;

   stc_ucode_rom u_rom (
      .upc  (upc_ff),
      .word (word)
   );

   stc_datapath u_dp (
      .clock        (clock),
      .load         (load),
      .load_seconds (req_unix_seconds),
      .step         (busy_ff),
      .word         (word),
      .taken        (taken),
      .year         (rsp_year),
      .month        (rsp_month),
      .day          (rsp_day),
      .hour         (rsp_hour),
      .minute       (rsp_minute),
      .second       (rsp_second)
   );

   // advance the step counter, hold on a repeating step while it subtracts
   always_comb begin
      busy_in  = busy_ff;
      upc_in   = upc_ff;
      valid_in = 1'b0;
      if (load) begin
         busy_in = 1'b1;
         upc_in  = UA_YEAR;
      end else if (busy_ff) begin
         if (word.last) begin
            busy_in  = 1'b0;
            valid_in = 1'b1;
         end else if (!(word.rep && taken)) begin
            upc_in = upc_ff + 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
         upc_ff   <= UA_YEAR;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
         upc_ff   <= upc_in;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = valid_ff;

endmodule

// ----- design/stc_checker.sv -----
// ----------------------------------------------------------------------------
// stc_checker: port-level checks for seconds_to_calendar
// Watches the command handshake and the result strobe over time.
// ----------------------------------------------------------------------------
module stc_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [11:0] rsp_year,
   input logic [3:0]  rsp_month,
   input logic [4:0]  rsp_day,
   input logic [4:0]  rsp_hour,
   input logic [5:0]  rsp_minute,
   input logic [5:0]  rsp_second
);

   // an accepted word makes the block busy
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy did not rise after an accepted word");

   // busy drops only when the result is shown
   a_done_strobe: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(busy) |-> rsp_valid)
      else $error("busy fell without a result strobe");

   // the strobe lasts one cycle and never overlaps busy
   a_strobe_short: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy ##1 !rsp_valid)
      else $error("result strobe overlapped busy or lasted too long");

   // result fields stay within calendar ranges
   a_fields_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_month >= 4'd1) && (rsp_month <= 4'd12) && (rsp_day >= 5'd1)
                    && (rsp_hour <= 5'd23) && (rsp_minute <= 6'd59)
                    && (rsp_second <= 6'd59) && (rsp_year >= 12'd1970)
                    && (rsp_year <= 12'd2106))
      else $error("result field out of range");

endmodule

bind seconds_to_calendar stc_checker u_stc_checker (.*);

// ----- dv/seconds_to_calendar_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// seconds_to_calendar_tb: self-checking bench for the seconds-to-calendar unit
// Sends Unix second counts over the start/busy port and predicts each UTC+8
// calendar word in the bench. Every rsp_valid word is checked field by field
// against the oldest prediction. Directed edges come first, then random
// counts and random calendar dates, with and without idle gaps.
// ----------------------------------------------------------------------------
module seconds_to_calendar_tb;

   localparam int unsigned SECS_PER_MIN  = 60;
   localparam int unsigned SECS_PER_HOUR = 3600;
   localparam int unsigned SECS_PER_DAY  = 86400;
   localparam int unsigned UTC8_OFFSET   = 8 * 3600;
   localparam int unsigned EPOCH_YEAR    = 1970;
   localparam int unsigned LAST_YEAR     = 2106;
   localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

   localparam int unsigned CLK_HALF         = 6;
   localparam int unsigned IDLE_PCT         = 27;
   localparam int unsigned MAX_GAP          = 180;
   localparam int unsigned STRAY_PCT        = 10;
   localparam int unsigned DRAIN_CYCLES     = 200;
   localparam int unsigned MAX_SHOWN        = 30;
   localparam int unsigned RUN_LIMIT_NS     = 20_000_000;

   // one predicted calendar word, tagged with the count that produced it
   typedef struct packed {
      logic [31:0] source;
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } date_word_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [31:0] req_unix_seconds;
   logic        rsp_valid;
   logic [11:0] rsp_year;
   logic [3:0]  rsp_month;
   logic [4:0]  rsp_day;
   logic [4:0]  rsp_hour;
   logic [5:0]  rsp_minute;
   logic [5:0]  rsp_second;

   date_word_type pending_dates[$];
   int unsigned   error_count = 0;
   bit            idle_on = 1'b1;
   bit            stray_on = 1'b0;

   seconds_to_calendar DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_unix_seconds (req_unix_seconds),
      .rsp_valid        (rsp_valid),
      .rsp_year         (rsp_year),
      .rsp_month        (rsp_month),
      .rsp_day          (rsp_day),
      .rsp_hour         (rsp_hour),
      .rsp_minute       (rsp_minute),
      .rsp_second       (rsp_second)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_HALF) clock = ~clock;
   end

   // hard stop for a hung handshake
   initial begin
      #(RUN_LIMIT_NS);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // ------------------------------------------------------------------------
   // calendar arithmetic
   // ------------------------------------------------------------------------
   function automatic bit is_leap(input int unsigned yr);
      return ((yr % 4) == 0 && (yr % 100) != 0) || (yr % 400) == 0;
   endfunction

   function automatic int unsigned year_days(input int unsigned yr);
      return is_leap(yr) ? 366 : 365;
   endfunction

   // month counted from 0 (January)
   function automatic int unsigned month_days(input int unsigned mon, input bit leap);
      return MONTH_DAYS[mon] + ((mon == 1 && leap) ? 1 : 0);
   endfunction

   // predict the UTC+8 calendar word for a Unix count
   function automatic date_word_type calendar_of(input logic [31:0] unix_secs);
      logic [31:0]   rest;
      int unsigned   yr;
      int unsigned   mon;
      bit            leap;
      date_word_type cal;
      // shift to local time, wrapping at 32 bits
      rest = unix_secs + UTC8_OFFSET;
      yr = EPOCH_YEAR;
      while (rest >= year_days(yr) * SECS_PER_DAY) begin
         rest -= year_days(yr) * SECS_PER_DAY;
         yr++;
      end
      // walk January to December
      leap = is_leap(yr);
      mon = 0;
      while (mon < 11 && rest >= month_days(mon, leap) * SECS_PER_DAY) begin
         rest -= month_days(mon, leap) * SECS_PER_DAY;
         mon++;
      end
      cal.source = unix_secs;
      cal.year   = 12'(yr);
      cal.month  = 4'(mon + 1);
      cal.day    = 5'(rest / SECS_PER_DAY + 1);
      rest %= SECS_PER_DAY;
      cal.hour   = 5'(rest / SECS_PER_HOUR);
      rest %= SECS_PER_HOUR;
      cal.minute = 6'(rest / SECS_PER_MIN);
      cal.second = 6'(rest % SECS_PER_MIN);
      return cal;
   endfunction

   // Unix count for a local UTC+8 date; month counted from 1, result wraps
   function automatic logic [31:0] local_to_unix(input int unsigned yr, mon, day, hh, mm, ss);
      longint unsigned days;
      days = day - 1;
      for (int unsigned y = EPOCH_YEAR; y < yr; y++) begin
         days += year_days(y);
      end
      for (int unsigned m = 0; m + 1 < mon; m++) begin
         days += month_days(m, is_leap(yr));
      end
      return 32'(days * SECS_PER_DAY + hh * SECS_PER_HOUR + mm * SECS_PER_MIN + ss
                 - UTC8_OFFSET);
   endfunction

   // random local date, biased toward the first and last second of a month
   function automatic logic [31:0] random_calendar_seconds();
      int unsigned yr;
      int unsigned mon;
      int unsigned day;
      int unsigned hh;
      int unsigned mm;
      int unsigned ss;
      yr  = $urandom_range(EPOCH_YEAR, LAST_YEAR);
      mon = $urandom_range(1, 12);
      day = $urandom_range(1, month_days(mon - 1, is_leap(yr)));
      hh  = $urandom_range(0, 23);
      mm  = $urandom_range(0, 59);
      ss  = $urandom_range(0, 59);
      case ($urandom_range(0, 3))
         0: begin
            day = month_days(mon - 1, is_leap(yr));
            hh = 23;
            mm = 59;
            ss = 59;
         end
         1: begin
            day = 1;
            hh = 0;
            mm = 0;
            ss = 0;
         end
         default: begin
         end
      endcase
      return local_to_unix(yr, mon, day, hh, mm, ss);
   endfunction

   // ------------------------------------------------------------------------
   // result checking
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= MAX_SHOWN) begin
         $display("MISMATCH at %0t ns: %s", $time, what);
      end
   endtask

   // compare each strobed word with the oldest prediction
   always @(posedge clock) begin
      date_word_type want;
      if (!reset) begin
         if (rsp_valid === 1'b1) begin
            if (pending_dates.size() == 0) begin
               report_mismatch($sformatf("unexpected word %0d-%0d-%0d %0d:%0d:%0d",
                  rsp_year, rsp_month, rsp_day, rsp_hour, rsp_minute, rsp_second));
            end else begin
               want = pending_dates.pop_front();
               if (rsp_year !== want.year)
                  report_mismatch($sformatf("secs %h: year %0d, want %0d",
                     want.source, rsp_year, want.year));
               if (rsp_month !== want.month)
                  report_mismatch($sformatf("secs %h: month %0d, want %0d",
                     want.source, rsp_month, want.month));
               if (rsp_day !== want.day)
                  report_mismatch($sformatf("secs %h: day %0d, want %0d",
                     want.source, rsp_day, want.day));
               if (rsp_hour !== want.hour)
                  report_mismatch($sformatf("secs %h: hour %0d, want %0d",
                     want.source, rsp_hour, want.hour));
               if (rsp_minute !== want.minute)
                  report_mismatch($sformatf("secs %h: minute %0d, want %0d",
                     want.source, rsp_minute, want.minute));
               if (rsp_second !== want.second)
                  report_mismatch($sformatf("secs %h: second %0d, want %0d",
                     want.source, rsp_second, want.second));
            end
         end else if (rsp_valid !== 1'b0) begin
            report_mismatch("rsp_valid unknown");
         end
      end
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   // Send one count: optionally idle first, then hold start until the word is
   // taken. Called in the time step of the previous accept, so start and the
   // data get one assignment per step.
   task automatic convert_seconds(input logic [31:0] unix_secs);
      logic [31:0] stray;
      int unsigned hold;
      if (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
         start <= 1'b0;
         req_unix_seconds <= $urandom;
         repeat ($urandom_range(1, MAX_GAP)) @(posedge clock);
      end
      start <= 1'b1;
      req_unix_seconds <= unix_secs;
      do @(posedge clock); while (busy !== 1'b0);
      pending_dates.push_back(calendar_of(unix_secs));
      // keep start up with a stray word while busy; drop it unless taken
      if (stray_on && $urandom_range(0, 99) < STRAY_PCT) begin
         stray = $urandom;
         req_unix_seconds <= stray;
         hold = $urandom_range(1, 8);
         while (hold > 0) begin
            @(posedge clock);
            if (busy === 1'b0) begin
               pending_dates.push_back(calendar_of(stray));
               hold = 0;
            end else begin
               hold--;
            end
         end
      end
   endtask

   // wrap of the local offset and the ends of the 32-bit range
   task automatic test_epoch_wrap();
      convert_seconds(local_to_unix(1970, 1, 1, 0, 0, 0));
      convert_seconds(32'hFFFF_FFFF);
      convert_seconds(32'h0000_0000);
      convert_seconds(32'hFFFF_8F7F);
      convert_seconds(32'hFFFF_8F80);
      convert_seconds(32'h8000_0000);
   endtask

   // year turnovers and the century leap rules
   task automatic test_year_edges();
      convert_seconds(local_to_unix(1970, 12, 31, 23, 59, 59));
      convert_seconds(local_to_unix(1971, 1, 1, 0, 0, 0));
      convert_seconds(local_to_unix(2000, 2, 29, 12, 0, 0));
      convert_seconds(local_to_unix(2000, 12, 31, 23, 59, 59));
      convert_seconds(local_to_unix(2100, 2, 28, 23, 59, 59));
      convert_seconds(local_to_unix(2100, 3, 1, 0, 0, 0));
   endtask

   // last second of every month in a leap year
   task automatic test_month_ends();
      for (int unsigned m = 1; m <= 12; m++) begin
         convert_seconds(local_to_unix(2024, m, month_days(m - 1, 1'b1), 23, 59, 59));
      end
   endtask

   // uniform counts with stray start pulses while busy
   task automatic test_random_seconds();
      stray_on = 1'b1;
      repeat (450) convert_seconds($urandom);
      stray_on = 1'b0;
   endtask

   task automatic test_random_dates();
      repeat (450) convert_seconds(random_calendar_seconds());
   endtask

   // long stretch with start never dropped
   task automatic test_back_to_back();
      idle_on = 1'b0;
      repeat (350) begin
         if ($urandom_range(0, 1) == 0)
            convert_seconds($urandom);
         else
            convert_seconds(random_calendar_seconds());
      end
      idle_on = 1'b1;
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_unix_seconds = 32'h0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_epoch_wrap();
      test_year_edges();
      test_month_ends();
      test_random_seconds();
      test_random_dates();
      test_back_to_back();

      // drop start, wait out the last words, then watch for strays
      start <= 1'b0;
      while (pending_dates.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ----- files.f -----
design/stc_pkg.sv
design/stc_ucode_rom.sv
design/stc_datapath.sv
design/seconds_to_calendar.sv
design/stc_checker.sv
dv/seconds_to_calendar_tb.sv
